>>> sv/ibd_pkg.sv
`default_nettype none

package ibd_pkg;

  // sample and pair sum widths
  localparam int SAMPLE_W = 16;
  localparam int PAIR_W   = SAMPLE_W + 1;
  localparam int SUM_W    = PAIR_W + 1;
  localparam int NCH      = 4;

  // apb register port
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  // register field widths
  localparam int WIDTH_W  = 12;
  localparam int HEIGHT_W = 16;
  localparam int CHAN_W   = 3;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [PAIR_W-1:0]   pair_t;
  typedef logic [SUM_W-1:0]    sum_t;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH   = 2'd0,
    REG_IMAGE_HEIGHT  = 2'd1,
    REG_CHANNEL_COUNT = 2'd2
  } reg_idx_e;

  // effective geometry after clamping of the raw registers
  typedef struct packed {
    logic [WIDTH_W-1:0]  width_last;
    logic [HEIGHT_W-1:0] height_last;
    logic [CHAN_W-1:0]   chan_num;
  } ibd_geom_t;

endpackage

`default_nettype wire

>>> sv/ibd_stream_if.sv
`default_nettype none

interface ibd_pix_if import ibd_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t pixel_ch0;
  sample_t pixel_ch1;
  sample_t pixel_ch2;
  sample_t pixel_ch3;

  modport source (output valid, pixel_ch0, pixel_ch1, pixel_ch2, pixel_ch3, input ready);
  modport sink   (input valid, pixel_ch0, pixel_ch1, pixel_ch2, pixel_ch3, output ready);
endinterface

interface ibd_avg_if import ibd_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t avg_ch0;
  sample_t avg_ch1;
  sample_t avg_ch2;
  sample_t avg_ch3;
  logic    end_of_row;
  logic    end_of_image;

  modport source (output valid, avg_ch0, avg_ch1, avg_ch2, avg_ch3, end_of_row,
                  end_of_image, input ready);
  modport sink   (input valid, avg_ch0, avg_ch1, avg_ch2, avg_ch3, end_of_row,
                  end_of_image, output ready);
endinterface

`default_nettype wire

>>> sv/ibd_ram.sv
`default_nettype none

module ibd_ram #(
  parameter int WIDTH = 68,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read returns the old word on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> sv/ibd_cfg.sv
`default_nettype none

module ibd_cfg import ibd_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready,
  output ibd_geom_t              geom_o
);

  logic [WIDTH_W-1:0]  width_q, width_d;
  logic [HEIGHT_W-1:0] height_q, height_d;
  logic [CHAN_W-1:0]   chan_q, chan_d;
  logic                wr_en;
  reg_idx_e            idx;
  logic [WIDTH_W-1:0]  width_eff;
  logic [CHAN_W-1:0]   chan_eff;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[3:2]);

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    chan_d   = chan_q;
    if (wr_en) begin
      case (idx)
        REG_IMAGE_WIDTH:   width_d  = pwdata[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT:  height_d = pwdata[HEIGHT_W-1:0];
        REG_CHANNEL_COUNT: chan_d   = pwdata[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_W'(1);
      height_q <= HEIGHT_W'(1);
      chan_q   <= CHAN_W'(3);
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      chan_q   <= chan_d;
    end
  end

  always_comb begin
    case (idx)
      REG_IMAGE_WIDTH:   prdata = CFG_DW'(width_q);
      REG_IMAGE_HEIGHT:  prdata = CFG_DW'(height_q);
      REG_CHANNEL_COUNT: prdata = CFG_DW'(chan_q);
      default:           prdata = '0;
    endcase
  end

  // zero acts as one, widths clamp to the line store size
  always_comb begin
    width_eff = (width_q == '0) ? WIDTH_W'(1) : width_q;
    if (32'(width_eff) > 32'(MAX_WIDTH)) begin
      width_eff = WIDTH_W'(MAX_WIDTH);
    end
    chan_eff = (chan_q == '0) ? CHAN_W'(1) : chan_q;
    if (chan_eff > CHAN_W'(NCH)) begin
      chan_eff = CHAN_W'(NCH);
    end
  end

  assign geom_o.width_last  = width_eff - WIDTH_W'(1);
  assign geom_o.height_last = (height_q == '0) ? '0 : height_q - HEIGHT_W'(1);
  assign geom_o.chan_num    = chan_eff;

endmodule

`default_nettype wire

>>> sv/image_half_downsample_box.sv
`default_nettype none
// 2x2 box downsampler, one source pixel per beat in raster order
// path: the input beat completing its block is captured in the input register,
//   then its average in the result register, which drives the result beat
// throughput: one input beat per cycle; input stalls only while a finished
//   average waits in the result register for the sink
// reset: counters, pixel hold and valid flags clear; line store is not cleared

module image_half_downsample_box import ibd_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  ibd_pix_if.sink                pix_in,
  ibd_avg_if.source              avg_out,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready
);

  localparam int PAIRS  = (MAX_WIDTH + 1) / 2;
  localparam int AW     = (PAIRS > 1) ? $clog2(PAIRS) : 1;
  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int XW     = (CW > WIDTH_W) ? CW : WIDTH_W;
  localparam int LINE_W = NCH * PAIR_W;

  ibd_geom_t geom;

  ibd_cfg #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .geom_o (geom)
  );

  // ------------------------------------------------------------------
  // accept side: position decode and counters
  // ------------------------------------------------------------------
  logic                in_acc;
  logic [CW-1:0]       col_q, col_d;
  logic [HEIGHT_W-1:0] row_q, row_d;
  logic                last_col, last_row;
  sample_t             in_raw [NCH];
  sample_t             in_smp [NCH];

  assign in_acc   = pix_in.valid & pix_in.ready;
  assign last_col = XW'(col_q) >= XW'(geom.width_last);
  assign last_row = row_q >= geom.height_last;

  assign in_raw[0] = pix_in.pixel_ch0;
  assign in_raw[1] = pix_in.pixel_ch1;
  assign in_raw[2] = pix_in.pixel_ch2;
  assign in_raw[3] = pix_in.pixel_ch3;

  // channels past the configured count enter as zero
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      in_smp[c] = (CHAN_W'(c) < geom.chan_num) ? in_raw[c] : '0;
    end
  end

  // counters wrap at the last column / last row, also after a shrink
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_acc) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + HEIGHT_W'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ------------------------------------------------------------------
  // input register stage
  // ------------------------------------------------------------------
  logic          s0_vld_q, s0_vld_d;
  sample_t       s0_smp_q [NCH];
  logic          s0_odd_col_q, s0_last_col_q, s0_odd_row_q, s0_last_row_q;
  logic [AW-1:0] s0_pair_q;
  logic          s0_fire;

  always_comb begin
    s0_vld_d = s0_vld_q;
    if (in_acc) begin
      s0_vld_d = 1'b1;
    end else if (s0_fire) begin
      s0_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else begin
      s0_vld_q <= s0_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s0_smp_q      <= in_smp;
      s0_odd_col_q  <= col_q[0];
      s0_last_col_q <= last_col;
      s0_odd_row_q  <= row_q[0];
      s0_last_row_q <= last_row;
      s0_pair_q     <= AW'(col_q >> 1);
    end
  end

  // ------------------------------------------------------------------
  // line store of horizontal pair sums, one word per pair of columns
  // read is issued on accept so the word is ready in the input stage
  // ------------------------------------------------------------------
  logic              ram_we;
  logic [LINE_W-1:0] ram_wdata, ram_rdata, line_word;
  logic [AW-1:0]     rd_addr;
  logic              byp_vld_q, byp_vld_d;
  logic [LINE_W-1:0] byp_data_q;

  assign rd_addr = AW'(col_q >> 1);

  ibd_ram #(
    .WIDTH(LINE_W),
    .DEPTH(PAIRS)
  ) u_line (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(s0_pair_q),
    .wdata_i(ram_wdata),
    .re_i   (in_acc),
    .raddr_i(rd_addr),
    .rdata_o(ram_rdata)
  );

  // a read that collides with the write of the same edge takes the new word
  // (narrow images: last pair of an even row, then the odd row right after)
  assign byp_vld_d = in_acc ? (ram_we && (s0_pair_q == rd_addr)) : byp_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_vld_q <= 1'b0;
    end else begin
      byp_vld_q <= byp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      byp_data_q <= ram_wdata;
    end
  end

  assign line_word = byp_vld_q ? byp_data_q : ram_rdata;

  // ------------------------------------------------------------------
  // pair sums, vertical add and mean
  // ------------------------------------------------------------------
  sample_t hold_q [NCH];
  pair_t   pair   [NCH];
  pair_t   above  [NCH];
  sum_t    sum    [NCH];
  sample_t avg    [NCH];
  logic    pair_rdy, store, emit;

  // a lone last column pairs with itself
  assign pair_rdy = s0_odd_col_q | s0_last_col_q;
  assign store    = pair_rdy & ~s0_odd_row_q & ~s0_last_row_q;
  assign emit     = pair_rdy & ~store;

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      pair[c] = s0_odd_col_q ? PAIR_W'(hold_q[c]) + PAIR_W'(s0_smp_q[c])
                             : {s0_smp_q[c], 1'b0};
      // last row of an odd height counts twice
      above[c] = s0_odd_row_q ? line_word[c*PAIR_W +: PAIR_W] : pair[c];
      sum[c]   = SUM_W'(above[c]) + SUM_W'(pair[c]);
      avg[c]   = sum[c][SUM_W-1:2];
      ram_wdata[c*PAIR_W +: PAIR_W] = pair[c];
    end
  end

  assign s0_fire = s0_vld_q & (~emit | ~avg_out.valid | avg_out.ready);
  assign ram_we  = s0_fire & store;

  assign pix_in.ready = ~s0_vld_q | s0_fire;

  // even column pixel waits for its right neighbor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NCH; c++) begin
        hold_q[c] <= '0;
      end
    end else if (s0_fire && !s0_odd_col_q) begin
      hold_q <= s0_smp_q;
    end
  end

  // ------------------------------------------------------------------
  // result register
  // ------------------------------------------------------------------
  logic    out_vld_q, out_vld_d, out_load;
  sample_t out_avg_q [NCH];
  logic    out_eor_q, out_eoi_q;

  assign out_load = s0_fire & emit;

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (avg_out.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_avg_q <= avg;
      out_eor_q <= s0_last_col_q;
      out_eoi_q <= s0_last_col_q & s0_last_row_q;
    end
  end

  assign avg_out.valid        = out_vld_q;
  assign avg_out.avg_ch0      = out_avg_q[0];
  assign avg_out.avg_ch1      = out_avg_q[1];
  assign avg_out.avg_ch2      = out_avg_q[2];
  assign avg_out.avg_ch3      = out_avg_q[3];
  assign avg_out.end_of_row   = out_eor_q;
  assign avg_out.end_of_image = out_eoi_q;

endmodule

`default_nettype wire
